// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the port window allocator.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, disabled while rst is high.
`define PWA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check on clk that also holds during reset.
`define PWA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/pwa_pkg.sv =====
// Package for the port window allocator: sizes, widths and opcodes.
// No dependencies.
`default_nettype none

package pwa_pkg;

  localparam int WINDOW_SIZE = 1024;
  localparam int WORD_W      = 32;
  localparam int NUM_WORDS   = WINDOW_SIZE / WORD_W;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int ADDR_W      = $clog2(NUM_WORDS);
  localparam int SLOT_W      = ADDR_W + BIT_W;
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);

  localparam int PORT_W      = 16;
  localparam int OPCODE_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int USE_W       = 11;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_START = 2'd0,
    REG_WINDOW_END   = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hdl/port_window_allocator.sv =====
// Port window allocator: bitmap of in-use marks in a word memory, lowest free first.
// Depends on pwa_pkg and assert_macros.svh.
//
//  channel | direction | signals
//  in      | sink      | in_valid, in_ready, opcode, port
//  out     | source    | out_valid, out_ready, port_result, ok, ports_in_use
//  cfg     | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// Each item is accepted with the bitmap word read, then modified and written back in S_MOD.
// The memory is used as a single read/write port; one item is in work at a time.
// Reset, clear and window writes invalidate all words at once through per-word valid flags.
// A result waits in the output register; the next item is accepted meanwhile, and
// its modify step holds until the output register is free.
`default_nettype none

module port_window_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [pwa_pkg::OPCODE_W-1:0]   opcode,
  input  wire logic [pwa_pkg::PORT_W-1:0]     port,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [pwa_pkg::PORT_W-1:0]     port_result,
  output      logic                           ok,
  output      logic [pwa_pkg::USE_W-1:0]      ports_in_use,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [pwa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pwa_pkg::CFG_DATA_W-1:0] cfg_data
);

  import pwa_pkg::*;

  typedef enum logic {S_IDLE, S_MOD} state_t;

  state_t                state;
  logic [PORT_W-1:0]     win_start;
  logic [PORT_W-1:0]     win_end;
  logic [NUM_WORDS-1:0]  word_valid;
  logic [NUM_WORDS-1:0]  word_full;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;

  opcode_t               op_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  in_win_q;
  logic                  any_free_q;
  logic                  rd_valid_q;
  logic [ADDR_W-1:0]     addr_q;

  logic [WORD_W-1:0]     mem [NUM_WORDS];
  logic [WORD_W-1:0]     rdata;

  function automatic logic [BIT_W-1:0] low_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] low_clear(input logic [NUM_WORDS-1:0] w);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (!w[i]) r = ADDR_W'(i);
    end
    return r;
  endfunction

  // window size after clamping
  logic [PORT_W:0]   lim;
  logic [PORT_W:0]   end_eff;
  logic [CNT_W-1:0]  slot_n;
  logic [PORT_W:0]   diff;
  logic              in_win;
  logic [ADDR_W-1:0] raddr;
  logic              accept;

  always_comb begin
    lim     = {1'b0, win_start} + (PORT_W + 1)'(WINDOW_SIZE);
    end_eff = ({1'b0, win_end} < lim) ? {1'b0, win_end} : lim;
    slot_n  = (end_eff > {1'b0, win_start}) ? CNT_W'(end_eff - {1'b0, win_start}) : '0;
    diff    = {1'b0, port} - {1'b0, win_start};
    in_win  = (port >= win_start) && (diff < (PORT_W + 1)'(slot_n));
    raddr   = (opcode_t'(opcode) == OP_ALLOC) ? low_clear(word_full) : diff[SLOT_W-1:BIT_W];
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // modify step
  logic              out_free;
  logic              advance;
  logic [WORD_W-1:0] word_cur;
  logic [WORD_W-1:0] word_new;
  logic [BIT_W-1:0]  bit_sel;
  logic [SLOT_W-1:0] k_alloc;
  logic              mod_we;
  logic              res_ok;
  logic [PORT_W-1:0] res_port;

  assign out_free = !out_valid || out_ready;
  assign advance  = (state == S_MOD) && out_free;

  always_comb begin
    word_cur   = rd_valid_q ? rdata : '0;
    bit_sel    = (op_q == OP_ALLOC) ? low_zero(word_cur) : slot_q[BIT_W-1:0];
    k_alloc    = {addr_q, bit_sel};
    word_new   = word_cur;
    mod_we     = 1'b0;
    res_ok     = 1'b0;
    res_port   = '0;
    count_next = count;
    case (op_q)
      OP_ALLOC: begin
        if (any_free_q && (CNT_W'(k_alloc) < slot_n)) begin
          word_new[bit_sel] = 1'b1;
          mod_we            = 1'b1;
          res_ok            = 1'b1;
          res_port          = win_start + PORT_W'(k_alloc);
          count_next        = count + CNT_W'(1);
        end
      end
      OP_FREE: begin
        if (in_win_q && word_cur[bit_sel]) begin
          word_new[bit_sel] = 1'b0;
          mod_we            = 1'b1;
          res_ok            = 1'b1;
          count_next        = count - CNT_W'(1);
        end
      end
      OP_QUERY: begin
        res_ok = in_win_q && word_cur[bit_sel];
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance && mod_we) mem[addr_q] <= word_new;
    if (accept) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      win_start  <= '0;
      win_end    <= '0;
      word_valid <= '0;
      word_full  <= '0;
      count      <= '0;
    end else begin
      if (out_valid && out_ready && !advance) out_valid <= 1'b0;

      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_START: begin
            win_start  <= cfg_data;
            word_valid <= '0;
            word_full  <= '0;
            count      <= '0;
          end
          REG_WINDOW_END: begin
            win_end    <= cfg_data;
            word_valid <= '0;
            word_full  <= '0;
            count      <= '0;
          end
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q       <= opcode_t'(opcode);
            slot_q     <= diff[SLOT_W-1:0];
            in_win_q   <= in_win;
            any_free_q <= !(&word_full);
            addr_q     <= raddr;
            rd_valid_q <= word_valid[raddr];
            state      <= S_MOD;
          end
        end
        S_MOD: begin
          if (out_free) begin
            port_result  <= res_port;
            ok           <= res_ok;
            ports_in_use <= USE_W'(count_next);
            out_valid    <= 1'b1;
            count        <= count_next;
            state        <= S_IDLE;
            if (op_q == OP_CLEAR) begin
              word_valid <= '0;
              word_full  <= '0;
            end else if (mod_we) begin
              word_valid[addr_q] <= 1'b1;
              word_full[addr_q]  <= &word_new;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `PWA_ASSERT(a_count_bound, count <= CNT_W'(WINDOW_SIZE), "in-use count beyond window size")
  `PWA_ASSERT_ALWAYS(a_full_valid, rst || ((word_full & ~word_valid) == '0), "full word not valid")
  `PWA_ASSERT(a_out_from_mod, $rose(out_valid) |-> $past(state == S_MOD), "result without modify")
  `PWA_ASSERT(a_accept_mod, accept |=> (state == S_MOD) && !in_ready, "accept did not start modify")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for port_window_allocator: a directed table, then random windows.
// Depends on pwa_pkg and the allocator RTL; results are predicted by an in-bench bitmap model.

module tb_top;
  import pwa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 45;
  localparam int LONG_HOLD     = 80;

  typedef struct packed {
    logic [PORT_W-1:0] port_result;
    logic              ok;
    logic [USE_W-1:0]  ports_in_use;
  } reply_t;

  typedef struct {
    bit                is_reg;
    logic [1:0]        code;
    logic [PORT_W-1:0] val;
    bit                typed;
    reply_t            want;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OPCODE_W-1:0]   opcode = '0;
  logic [PORT_W-1:0]     port = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PORT_W-1:0]     port_result;
  logic                  ok;
  logic [USE_W-1:0]      ports_in_use;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit          slot_mark [WINDOW_SIZE];
  int          marks_set;
  int          win_lo;
  int          win_hi;
  reply_t      owed_replies [$];
  step_row_t   script [$];
  int unsigned fails;
  bit          calm;

  port_window_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .port         (port),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .port_result  (port_result),
    .ok           (ok),
    .ports_in_use (ports_in_use),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  function automatic void wipe_marks();
    foreach (slot_mark[k]) slot_mark[k] = 1'b0;
    marks_set = 0;
  endfunction

  function automatic int usable_slots();
    int lim;
    int stop;
    lim = win_lo + WINDOW_SIZE;
    stop = (win_hi < lim) ? win_hi : lim;
    return (stop > win_lo) ? stop - win_lo : 0;
  endfunction

  function automatic int slot_of(input logic [PORT_W-1:0] p);
    int pi;
    pi = int'(p);
    if (pi < win_lo || pi - win_lo >= usable_slots()) return -1;
    return pi - win_lo;
  endfunction

  function automatic reply_t allocator_step(input opcode_t op, input logic [PORT_W-1:0] p);
    reply_t r;
    int     n;
    int     s;
    r = '0;
    case (op)
      OP_ALLOC: begin
        n = usable_slots();
        for (int k = 0; k < n && !r.ok; k++) begin
          if (!slot_mark[k]) begin
            slot_mark[k] = 1'b1;
            marks_set++;
            r.port_result = PORT_W'(win_lo + k);
            r.ok = 1'b1;
          end
        end
      end
      OP_FREE: begin
        s = slot_of(p);
        if (s >= 0 && slot_mark[s]) begin
          slot_mark[s] = 1'b0;
          marks_set--;
          r.ok = 1'b1;
        end
      end
      OP_QUERY: begin
        s = slot_of(p);
        if (s >= 0 && slot_mark[s]) r.ok = 1'b1;
      end
      default: wipe_marks();
    endcase
    r.ports_in_use = USE_W'(marks_set);
    return r;
  endfunction

  function automatic step_row_t item_row(input opcode_t op, input logic [PORT_W-1:0] p,
                                         input bit typed, input logic [PORT_W-1:0] pr,
                                         input logic okv, input logic [USE_W-1:0] busy);
    step_row_t row;
    row.is_reg = 1'b0;
    row.code   = op;
    row.val    = p;
    row.typed  = typed;
    row.want   = '{port_result: pr, ok: okv, ports_in_use: busy};
    return row;
  endfunction

  function automatic step_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] v);
    step_row_t row;
    row.is_reg = 1'b1;
    row.code   = idx;
    row.val    = v;
    row.typed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic logic [PORT_W-1:0] pick_port();
    int n;
    int r;
    n = usable_slots();
    r = $urandom_range(0, 9);
    if (r < 7 && n > 0) return PORT_W'(win_lo + $urandom_range(0, n - 1));
    if (r == 7) return PORT_W'(win_lo + n);
    if (r == 8) return PORT_W'(win_lo - 1);
    return PORT_W'($urandom);
  endfunction

  task automatic report(input string msg);
    fails++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_reply();
    reply_t want;
    if (owed_replies.size() == 0) begin
      report($sformatf("result beat with nothing owed: port_result=%0d ok=%0d ports_in_use=%0d",
                       port_result, ok, ports_in_use));
    end else begin
      want = owed_replies.pop_front();
      if (port_result !== want.port_result)
        report($sformatf("port_result %0d, want %0d", port_result, want.port_result));
      if (ok !== want.ok)
        report($sformatf("ok %0d, want %0d", ok, want.ok));
      if (ports_in_use !== want.ports_in_use)
        report($sformatf("ports_in_use %0d, want %0d", ports_in_use, want.ports_in_use));
    end
  endtask

  task automatic send_item(input opcode_t op, input logic [PORT_W-1:0] p,
                           input bit typed, input reply_t want);
    reply_t predicted;
    cfg_valid <= 1'b0;
    in_valid  <= 1'b1;
    opcode    <= op;
    port      <= p;
    do @(posedge clk); while (!in_ready);
    predicted = allocator_step(op, p);
    owed_replies.push_back(typed ? want : predicted);
  endtask

  // leave cfg_valid high; the next item or register write takes it over
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WINDOW_START: begin
        win_lo = int'(v);
        wipe_marks();
      end
      REG_WINDOW_END: begin
        win_hi = int'(v);
        wipe_marks();
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic set_window();
    int s;
    int e;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        s = $urandom_range(0, 65455);
        e = s + $urandom_range(1, 70);
      end
      5: begin
        s = $urandom_range(0, 65535);
        e = 65535;
      end
      6: begin
        s = $urandom_range(65495, 65535);
        e = 65535;
      end
      7: begin
        s = $urandom_range(1, 65535);
        e = $urandom_range(0, s);
      end
      8: begin
        s = 0;
        e = $urandom_range(1, 100);
      end
      default: begin
        s = $urandom_range(0, 65135);
        e = s + $urandom_range(200, 400);
      end
    endcase
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_WINDOW_START, CFG_DATA_W'(s));
      write_reg(REG_WINDOW_END, CFG_DATA_W'(e));
    end else begin
      write_reg(REG_WINDOW_END, CFG_DATA_W'(e));
      write_reg(REG_WINDOW_START, CFG_DATA_W'(s));
    end
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
  endtask

  // result side: random stalls, one long hold once the block has had time to fill
  initial begin : result_side
    int stall;
    int hold;
    int seen;
    stall = 0;
    hold  = 0;
    seen  = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        check_reply();
        seen++;
        if (seen == 150) hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    opcode_t          op;
    logic [PORT_W-1:0] p;
    int               r;

    fails = 0;
    calm  = 1'b0;
    win_lo = 0;
    win_hi = 0;
    wipe_marks();

    // reset window is empty
    script.push_back(item_row(OP_ALLOC, 16'h0000, 1, 16'd0, 1'b0, 11'd0));
    script.push_back(item_row(OP_QUERY, 16'h0000, 1, 16'd0, 1'b0, 11'd0));
    script.push_back(item_row(OP_FREE,  16'hFFFF, 1, 16'd0, 1'b0, 11'd0));
    script.push_back(item_row(OP_CLEAR, 16'hFFFF, 1, 16'd0, 1'b0, 11'd0));
    // three-port window from zero: ports zero to two granted, then full
    script.push_back(reg_row(REG_WINDOW_START, 16'd0));
    script.push_back(reg_row(REG_WINDOW_END,   16'd3));
    script.push_back(item_row(OP_ALLOC, 16'hFFFF, 1, 16'd0, 1'b1, 11'd1));
    script.push_back(item_row(OP_ALLOC, 16'h0000, 1, 16'd1, 1'b1, 11'd2));
    script.push_back(item_row(OP_ALLOC, 16'h5555, 1, 16'd2, 1'b1, 11'd3));
    script.push_back(item_row(OP_ALLOC, 16'hAAAA, 1, 16'd0, 1'b0, 11'd3));
    script.push_back(item_row(OP_QUERY, 16'd1,    1, 16'd0, 1'b1, 11'd3));
    script.push_back(item_row(OP_QUERY, 16'd3,    1, 16'd0, 1'b0, 11'd3));
    script.push_back(item_row(OP_FREE,  16'd1,    1, 16'd0, 1'b1, 11'd2));
    script.push_back(item_row(OP_FREE,  16'd1,    1, 16'd0, 1'b0, 11'd2));
    script.push_back(item_row(OP_ALLOC, 16'd7,    0, '0, 1'b0, '0));
    script.push_back(item_row(OP_CLEAR, 16'd0,    1, 16'd0, 1'b0, 11'd0));
    // inverted window
    script.push_back(reg_row(REG_WINDOW_START, 16'd100));
    script.push_back(reg_row(REG_WINDOW_END,   16'd50));
    script.push_back(item_row(OP_ALLOC, 16'd0,    1, 16'd0, 1'b0, 11'd0));
    script.push_back(item_row(OP_QUERY, 16'd75,   1, 16'd0, 1'b0, 11'd0));
    // oversized window clamps to start plus window size
    script.push_back(reg_row(REG_WINDOW_START, 16'd16));
    script.push_back(reg_row(REG_WINDOW_END,   16'hFFFF));
    script.push_back(item_row(OP_ALLOC, 16'd0,    1, 16'd16, 1'b1, 11'd1));
    script.push_back(item_row(OP_QUERY, 16'd1040, 1, 16'd0,  1'b0, 11'd1));
    script.push_back(item_row(OP_FREE,  16'd1039, 1, 16'd0,  1'b0, 11'd1));
    // spare index leaves the marks alone; a window write wipes them
    script.push_back(reg_row(REG_SPARE_2, 16'hFFFF));
    script.push_back(item_row(OP_QUERY, 16'd16,   1, 16'd0, 1'b1, 11'd1));
    script.push_back(reg_row(REG_WINDOW_START, 16'd16));
    script.push_back(item_row(OP_QUERY, 16'd16,   1, 16'd0, 1'b0, 11'd0));
    // empty window at the top of the range
    script.push_back(reg_row(REG_WINDOW_START, 16'hFFFF));
    script.push_back(item_row(OP_ALLOC, 16'd0,    1, 16'd0, 1'b0, 11'd0));
    script.push_back(reg_row(REG_SPARE_3, 16'h0000));
    script.push_back(reg_row(REG_WINDOW_START, 16'hFC00));
    script.push_back(item_row(OP_ALLOC, 16'd0,    1, 16'hFC00, 1'b1, 11'd1));
    script.push_back(item_row(OP_FREE,  16'hFC00, 1, 16'd0,    1'b1, 11'd0));
    script.push_back(item_row(OP_QUERY, 16'hFFFF, 1, 16'd0,    1'b0, 11'd0));
    script.push_back(item_row(OP_QUERY, 16'hFC01, 0, '0, 1'b0, '0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        if (i == 0 || !script[i-1].is_reg) wait_idle();
        write_reg(script[i].code, script[i].val);
      end else begin
        send_item(opcode_t'(script[i].code), script[i].val, script[i].typed, script[i].want);
        maybe_gap();
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      if (ph == RANDOM_PHASES - 1) calm = 1'b1;
      set_window();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold the sender until every owed result is back
        if (ph == 2 && i == PHASE_ITEMS / 2) wait_idle();
        r = $urandom_range(0, 99);
        if (r < 45) begin
          op = OP_ALLOC;
          p  = PORT_W'($urandom);
        end else if (r < 75) begin
          op = OP_FREE;
          p  = pick_port();
        end else if (r < 97) begin
          op = OP_QUERY;
          p  = pick_port();
        end else begin
          op = OP_CLEAR;
          p  = PORT_W'($urandom);
        end
        send_item(op, p, 1'b0, '0);
        maybe_gap();
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (fails == 0 && owed_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
